[rtl/nps_pkg.sv]
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int PRIO_BITS   = 4;
  localparam int BURST_BITS  = 16;
  localparam int TIME_BITS   = 32;
  localparam int KIND_BITS   = 2;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CMDQ_DEPTH  = 4;
  localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);

  // Event codes on the result channel.
  localparam logic [KIND_BITS-1:0] EV_START  = 2'd0;
  localparam logic [KIND_BITS-1:0] EV_FINISH = 2'd1;
  localparam logic [KIND_BITS-1:0] EV_REJECT = 2'd2;

  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic [PRIO_BITS-1:0]  prio;
    logic [BURST_BITS-1:0] burst;
  } slot_t;

  typedef struct packed {
    logic  is_tick;
    slot_t job;
  } cmd_t;

endpackage

[rtl/nps_if.sv]
// ----------------------------------------------------------------------------
// nps_in_if / nps_out_if
// Valid/ready channels for arrival and tick words and for scheduler events.
// ----------------------------------------------------------------------------
interface nps_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  job_id;
  logic [3:0]  job_priority;
  logic [15:0] job_burst;

  modport source (output valid, mode, job_id, job_priority, job_burst, input ready);
  modport sink   (input valid, mode, job_id, job_priority, job_burst, output ready);
endinterface

interface nps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  event_job_id;
  logic [31:0] event_time;
  logic        last;

  modport source (output valid, event_kind, event_job_id, event_time, last, input ready);
  modport sink   (input valid, event_kind, event_job_id, event_time, last, output ready);
endinterface

[rtl/nps_front.sv]
// ----------------------------------------------------------------------------
// nps_front
// Accepts input words, classifies them as arrival or tick and holds them
// in a short command queue for the engine.
// ----------------------------------------------------------------------------
module nps_front import nps_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  nps_in_if.sink  in_ch,
  output cmd_t    cmd,
  output logic    cmd_valid,
  input  logic    cmd_pop
);

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r;
  logic [CMDQ_AW-1:0] rd_ptr_r;
  logic [CMDQ_AW:0]   cnt_r;
  logic               push;
  logic               pop;
  cmd_t               in_cmd;

  // Classify the incoming word.
  always_comb begin
    in_cmd.is_tick   = in_ch.mode;
    in_cmd.job.id    = in_ch.job_id;
    in_cmd.job.prio  = in_ch.job_priority;
    in_cmd.job.burst = in_ch.job_burst;
  end

  assign in_ch.ready = (cnt_r != (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != '0);
  assign pop         = cmd_pop && cmd_valid;
  assign cmd         = mem_r[rd_ptr_r];

  // Command storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/nps_back.sv]
// ----------------------------------------------------------------------------
// nps_back
// Scheduling engine: keeps the sorted ready queue and the running job,
// applies one command at a time and issues up to two events for it.
// ----------------------------------------------------------------------------
module nps_back import nps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic       cmd_valid,
  output logic       cmd_pop,
  nps_out_if.source  out_ch
);

  localparam logic [1:0] ST_EXEC   = 2'd0;
  localparam logic [1:0] ST_DECIDE = 2'd1;
  localparam logic [1:0] ST_OUT1   = 2'd2;
  localparam logic [1:0] ST_OUT2   = 2'd3;

  logic [1:0]            state_r, state_nxt;
  slot_t                 q_r [QUEUE_DEPTH];
  slot_t                 q_nxt [QUEUE_DEPTH];
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  running_r, running_nxt;
  logic [ID_BITS-1:0]    run_id_r, run_id_nxt;
  logic [BURST_BITS-1:0] run_burst_r, run_burst_nxt;
  logic [BURST_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [TIME_BITS-1:0]  time_r, time_nxt;
  logic                  a_vld_r, a_vld_nxt;
  logic [KIND_BITS-1:0]  a_kind_r, a_kind_nxt;
  logic [ID_BITS-1:0]    a_id_r, a_id_nxt;
  logic                  b_vld_r, b_vld_nxt;
  logic [ID_BITS-1:0]    b_id_r, b_id_nxt;
  logic                  ov_r, ov_nxt;
  logic [KIND_BITS-1:0]  okind_r, okind_nxt;
  logic [ID_BITS-1:0]    oid_r, oid_nxt;
  logic [TIME_BITS-1:0]  otime_r, otime_nxt;
  logic                  olast_r, olast_nxt;
  logic                  out_free;
  logic [CNT_W-1:0]      pos;
  logic                  tail_ge;
  logic                  start;
  logic [BURST_BITS-1:0] el_inc;

  assign out_free = !ov_r || out_ch.ready;
  assign start    = !running_r && (count_r != '0);
  assign el_inc   = (elapsed_r != '1) ? elapsed_r + 1'b1 : elapsed_r;

  // Insertion position from parallel priority compares over the queue.
  always_comb begin
    tail_ge = 1'b0;
    pos     = count_r - 1'b1;
    for (int i = QUEUE_DEPTH - 1; i >= 1; i--) begin
      if ((CNT_W'(i) < count_r) && (cmd.job.prio <= q_r[i].prio)) begin
        pos = CNT_W'(i);
      end
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if ((CNT_W'(i) == count_r - 1'b1) && (cmd.job.prio >= q_r[i].prio)) begin
        tail_ge = 1'b1;
      end
    end
    if (count_r == '0 || cmd.job.prio <= q_r[0].prio) begin
      pos = '0;
    end else if (tail_ge) begin
      pos = count_r;
    end
  end

  // Sequencer: apply command, decide on a start, then issue events.
  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    count_nxt     = count_r;
    running_nxt   = running_r;
    run_id_nxt    = run_id_r;
    run_burst_nxt = run_burst_r;
    elapsed_nxt   = elapsed_r;
    time_nxt      = time_r;
    a_vld_nxt     = a_vld_r;
    a_kind_nxt    = a_kind_r;
    a_id_nxt      = a_id_r;
    b_vld_nxt     = b_vld_r;
    b_id_nxt      = b_id_r;
    ov_nxt        = ov_r && !out_ch.ready;
    okind_nxt     = okind_r;
    oid_nxt       = oid_r;
    otime_nxt     = otime_r;
    olast_nxt     = olast_r;
    cmd_pop       = 1'b0;
    case (state_r)
      ST_EXEC: begin
        a_vld_nxt = 1'b0;
        b_vld_nxt = 1'b0;
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          state_nxt = ST_DECIDE;
          if (!cmd.is_tick) begin
            if (count_r >= CNT_W'(QUEUE_DEPTH)) begin
              a_vld_nxt  = 1'b1;
              a_kind_nxt = EV_REJECT;
              a_id_nxt   = cmd.job.id;
            end else begin
              if (pos == '0) begin
                q_nxt[0] = cmd.job;
              end
              for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (CNT_W'(i) == pos) begin
                  q_nxt[i] = cmd.job;
                end else if (CNT_W'(i) > pos) begin
                  q_nxt[i] = q_r[i-1];
                end
              end
              count_nxt = count_r + 1'b1;
            end
          end else begin
            if (time_r != '1) begin
              time_nxt = time_r + 1'b1;
            end
            if (running_r) begin
              elapsed_nxt = el_inc;
              if (el_inc >= run_burst_r) begin
                a_vld_nxt   = 1'b1;
                a_kind_nxt  = EV_FINISH;
                a_id_nxt    = run_id_r;
                running_nxt = 1'b0;
              end
            end
          end
        end
      end
      ST_DECIDE: begin
        state_nxt = ST_OUT1;
        if (start) begin
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            q_nxt[i] = q_r[i+1];
          end
          count_nxt     = count_r - 1'b1;
          running_nxt   = 1'b1;
          run_id_nxt    = q_r[0].id;
          run_burst_nxt = q_r[0].burst;
          elapsed_nxt   = '0;
          b_vld_nxt     = 1'b1;
          b_id_nxt      = q_r[0].id;
        end
      end
      ST_OUT1: begin
        if (!a_vld_r) begin
          state_nxt = ST_OUT2;
        end else if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = a_kind_r;
          oid_nxt   = a_id_r;
          otime_nxt = time_r;
          olast_nxt = !b_vld_r;
          state_nxt = ST_OUT2;
        end
      end
      ST_OUT2: begin
        if (!b_vld_r) begin
          state_nxt = ST_EXEC;
        end else if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = EV_START;
          oid_nxt   = b_id_r;
          otime_nxt = time_r;
          olast_nxt = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      default: begin
        state_nxt = ST_EXEC;
      end
    endcase
  end

  // Ready queue entries and event payload.
  always_ff @(posedge clk) begin
    q_r         <= q_nxt;
    run_id_r    <= run_id_nxt;
    run_burst_r <= run_burst_nxt;
    a_kind_r    <= a_kind_nxt;
    a_id_r      <= a_id_nxt;
    b_id_r      <= b_id_nxt;
    okind_r     <= okind_nxt;
    oid_r       <= oid_nxt;
    otime_r     <= otime_nxt;
    olast_r     <= olast_nxt;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_EXEC;
      count_r   <= '0;
      running_r <= 1'b0;
      elapsed_r <= '0;
      time_r    <= '0;
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      running_r <= running_nxt;
      elapsed_r <= elapsed_nxt;
      time_r    <= time_nxt;
      a_vld_r   <= a_vld_nxt;
      b_vld_r   <= b_vld_nxt;
      ov_r      <= ov_nxt;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.event_kind   = okind_r;
  assign out_ch.event_job_id = oid_r;
  assign out_ch.event_time   = otime_r;
  assign out_ch.last         = olast_r;

`ifndef ASSERT_OFF
  // The queue never holds more jobs than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("ready queue count exceeds depth");

  // Between commands an idle engine always has an empty queue.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> (running_r || count_r == '0))
    else $error("idle with jobs waiting");

  // A start decision leaves a job running.
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && start) |=> running_r)
    else $error("start did not set running job");
`endif

endmodule

[rtl/nonpreemptive_priority_scheduler.sv]
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler
// Non-preemptive priority job dispatcher with a sorted ready queue.
// ----------------------------------------------------------------------------
// Usage: in_ch carries one word per arrival (mode 0, with id, priority and
// burst) or per time tick (mode 1). out_ch carries job started, job finished
// and arrival rejected events, each stamped with the tick count; last marks
// the final event caused by a word. A word causes zero, one or two events.
// The front stage takes words into a four-word command queue; the engine
// handles each word in turn (apply, start decision, two event slots) and
// takes the next one only after the last slot; an event slot waits while
// out_ch is stalled. The word rate is set by the engine's sequencer,
// which owns the ready queue.
// Reset clears the queue, the running job and the tick count; queue entries
// themselves are not cleared. When out_ch stalls, the event register holds
// its word, the engine waits, and the command queue absorbs up to four more
// words before in_ch.ready drops.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler import nps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  nps_in_if.sink     in_ch,
  nps_out_if.source  out_ch
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  nps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  nps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule

[verif/nps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_checker
// Watches the arrival/tick channel and the event channel of the scheduler,
// predicts every event from the accepted words and compares field by field.
// ----------------------------------------------------------------------------
module nps_checker import nps_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  nps_in_if     in_ch,
  nps_out_if    out_ch,
  output int    fail_count,
  output int    pending_events,
  output int    event_total
);

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] stamp;
    logic                 last;
  } event_t;

  event_t                expected_events[$];
  slot_t                 job_list[$];
  logic                  busy;
  logic [ID_BITS-1:0]    run_id;
  logic [BURST_BITS-1:0] run_burst;
  logic [BURST_BITS-1:0] run_elapsed;
  logic [TIME_BITS-1:0]  tick_count;

  assign pending_events = expected_events.size();

  // Apply one accepted word to the shadow scheduler and queue its events.
  task automatic predict_word(input logic mode, input slot_t job);
    event_t ev[$];
    int     pos;
    if (!mode) begin
      if (job_list.size() >= QUEUE_DEPTH) begin
        ev.insert(ev.size(), '{EV_REJECT, job.id, tick_count, 1'b0});
      end else begin
        if (job_list.size() == 0 || job.prio <= job_list[0].prio) begin
          pos = 0;
        end else if (job.prio >= job_list[job_list.size()-1].prio) begin
          pos = job_list.size();
        end else begin
          pos = job_list.size() - 1;
          for (int i = 1; i < job_list.size(); i++) begin
            if (job.prio <= job_list[i].prio) begin
              pos = i;
              break;
            end
          end
        end
        job_list.insert(pos, job);
      end
    end else begin
      if (tick_count != '1) tick_count++;
      if (busy) begin
        if (run_elapsed != '1) run_elapsed++;
        if (run_elapsed >= run_burst) begin
          ev.insert(ev.size(), '{EV_FINISH, run_id, tick_count, 1'b0});
          busy = 1'b0;
        end
      end
    end
    // Start the queue head whenever the engine is idle.
    if (!busy && job_list.size() > 0) begin
      busy        = 1'b1;
      run_id      = job_list[0].id;
      run_burst   = job_list[0].burst;
      run_elapsed = '0;
      job_list.delete(0);
      ev.insert(ev.size(), '{EV_START, run_id, tick_count, 1'b0});
    end
    if (ev.size() > 0) ev[ev.size()-1].last = 1'b1;
    foreach (ev[i]) expected_events.insert(expected_events.size(), ev[i]);
  endtask

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    event_t got;
    event_t want;
    if (!rst_n) begin
      expected_events.delete();
      job_list.delete();
      busy        = 1'b0;
      run_id      = '0;
      run_burst   = '0;
      run_elapsed = '0;
      tick_count  = '0;
      fail_count  <= 0;
      event_total <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.event_kind, out_ch.event_job_id, out_ch.event_time, out_ch.last};
        event_total <= event_total + 1;
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_events[0];
          expected_events.delete(0);
          if (got !== want) begin
            $display("%0t: event mismatch, expected kind %0d id %0d time %0d last %0d,",
                     $time, want.kind, want.id, want.stamp, want.last);
            $display("%0t:   actual kind %0d id %0d time %0d last %0d",
                     $time, got.kind, got.id, got.stamp, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_word(in_ch.mode, '{in_ch.job_id, in_ch.job_priority, in_ch.job_burst});
    end
  end

endmodule

[verif/nonpreemptive_priority_scheduler_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_tb
// Drives arrival and tick words into the scheduler under several idling
// phases and a long output stall; the checker predicts and compares events.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_tb;
  import nps_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_events;
  int   event_total;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_cycles;
  int   idle_count;
  int   word_count;

  nps_in_if  in_ch();
  nps_out_if out_ch();

  nonpreemptive_priority_scheduler uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  nps_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending_events(pending_events),
    .event_total(event_total)
  );

  // Clock with a 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: random stalls, or a counted hold-off when requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_cycles > 0)
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired at %0t", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one word, with a random gap first, and wait for acceptance.
  // Valid stays high afterwards so the next word can follow at once; the
  // caller drops it before any pause.
  task automatic send_word(input logic mode, input logic [7:0] id,
                           input logic [3:0] prio, input logic [15:0] burst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.job_id       <= id;
    in_ch.job_priority <= prio;
    in_ch.job_burst    <= burst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    word_count++;
  endtask

  // Random tick or arrival, arrivals with mostly short bursts so jobs keep finishing.
  task automatic send_random_word();
    logic [15:0] burst;
    if ($urandom_range(99) < 55) begin
      send_word(1'b1, 8'($urandom), 4'($urandom), 16'($urandom));
    end else begin
      case ($urandom_range(9))
        0:       burst = 16'($urandom);
        1:       burst = 16'hffff;
        2:       burst = 16'h0000;
        default: burst = 16'($urandom_range(6));
      endcase
      send_word(1'b0, 8'($urandom), 4'($urandom), burst);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_events > 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.mode         = 1'b0;
    in_ch.job_id       = '0;
    in_ch.job_priority = '0;
    in_ch.job_burst    = '0;
    out_ch.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_cycles        = 0;
    idle_count         = 0;
    word_count         = 0;
    rst_n              = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: idle tick, zero burst, insertion at front, back and middle.
    send_word(1'b1, 8'h00, 4'h0, 16'h0000);
    send_word(1'b0, 8'hff, 4'hf, 16'h0000);
    send_word(1'b0, 8'h01, 4'h8, 16'h0002);
    send_word(1'b0, 8'h02, 4'h0, 16'hffff);
    send_word(1'b0, 8'h03, 4'hf, 16'h0001);
    send_word(1'b0, 8'h04, 4'h4, 16'h0001);
    send_word(1'b0, 8'h05, 4'h8, 16'h0001);
    send_word(1'b1, 8'h00, 4'h0, 16'h0000);
    send_word(1'b1, 8'hff, 4'hf, 16'hffff);
    // Overfill the queue so arrivals are rejected.
    for (int i = 0; i < 16; i++) send_word(1'b0, 8'(8'h10 + i), 4'($urandom), 16'h0001);
    drain();
    for (int i = 0; i < 25; i++) send_word(1'b1, 8'h00, 4'h0, 16'h0000);
    drain();

    // Random phases over the idling mixes.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int i = 0; i < 140; i++) send_random_word();
      if (phase == 1) drain();
    end

    // Long receiver hold-off while arrivals keep coming, then a full drain.
    in_ch.valid    <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_random_word();
    drain();

    $display("Sent %0d words over four idling mixes and a long stall; %0d events checked.",
             word_count, event_total);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
